// ===== hw/rtl/wsf_pkg.sv =====
// Shared constants, opcodes and register indexes of the WalkSAT flip engine.
`timescale 1ns / 1ps

package wsf_pkg;

    localparam int DEF_MAX_VARS     = 1024;
    localparam int DEF_MAX_CLAUSES  = 4096;
    localparam int DEF_MAX_LITERALS = 16384;

    // width of the random words that the remainder unit divides
    localparam int RAND_W = 31;

    localparam int DEF_DIV_W = 15;

    localparam logic [10:0] VAR_COUNT_RST = 11'd1024;
    localparam logic [16:0] GREEDY_RST    = 17'd32768;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SET  = 2'd1,
        OP_FLIP = 2'd2,
        OP_READ = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_VAR_COUNT = 1'b0,
        CFG_GREEDY    = 1'b1
    } t_cfg_index;

endpackage

// ===== hw/rtl/wsf_rem.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module wsf_rem import wsf_pkg::*; #(
    parameter int DW = DEF_DIV_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [DW-1:0]     i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_rem
);

    localparam int CNTW = $clog2(RAND_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [RAND_W-1:0] r_q;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_d;

    logic [DW:0]   w_t;
    logic          w_ge;
    logic [DW-1:0] w_nrem;

    always_comb begin
        w_t    = {r_rem, r_q[RAND_W-1]};
        w_ge   = w_t >= {1'b0, r_d};
        w_nrem = w_ge ? DW'(w_t - {1'b0, r_d}) : DW'(w_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_nrem;
                r_q   <= r_q << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/walksat_flip_engine.sv =====
// WalkSAT flip engine: formula store, assignment bits and the flip sequencer.
// A flip step scans the formula through one shared clause evaluator, reading the literals
// of each clause up to the first true one; a greedy move repeats that scan once per live
// literal of the chosen clause, and each modulo is computed in the bit-serial remainder unit.
// After reset the assignment memory is cleared before the first item is accepted.
`timescale 1ns / 1ps

module walksat_flip_engine import wsf_pkg::*; #(
    parameter int MAX_VARS     = DEF_MAX_VARS,
    parameter int MAX_CLAUSES  = DEF_MAX_CLAUSES,
    parameter int MAX_LITERALS = DEF_MAX_LITERALS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [11:0] i_literal,
    input  logic               i_clause_end,
    input  logic [10:0]        i_var_index,
    input  logic               i_var_value,
    input  logic [30:0]        i_rand_clause,
    input  logic [15:0]        i_rand_coin,
    input  logic [30:0]        i_rand_literal,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_all_satisfied,
    output logic [10:0]        o_flipped_var,
    output logic [12:0]        o_unsat_count,
    output logic               o_read_value,
    output logic               o_load_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    localparam int LW  = $clog2(MAX_LITERALS + 1);
    localparam int LAW = (MAX_LITERALS > 1) ? $clog2(MAX_LITERALS) : 1;
    localparam int CW  = $clog2(MAX_CLAUSES + 1);
    localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int VW  = $clog2(MAX_VARS + 1);
    localparam int DW  = (LW > CW) ? LW : CW;

    typedef enum logic [19:0] {
        S_CLEAR    = 20'(1) << 0,
        S_IDLE     = 20'(1) << 1,
        S_RD       = 20'(1) << 2,
        S_SC_START = 20'(1) << 3,
        S_SC_OFF   = 20'(1) << 4,
        S_SC_LIT   = 20'(1) << 5,
        S_SC_LW    = 20'(1) << 6,
        S_SC_EV    = 20'(1) << 7,
        S_DIV1     = 20'(1) << 8,
        S_PK1      = 20'(1) << 9,
        S_PK2      = 20'(1) << 10,
        S_PK3      = 20'(1) << 11,
        S_PK4      = 20'(1) << 12,
        S_DIV2     = 20'(1) << 13,
        S_RND_LW   = 20'(1) << 14,
        S_GR_LIT   = 20'(1) << 15,
        S_GR_LW    = 20'(1) << 16,
        S_FLIP     = 20'(1) << 17,
        S_FLIP2    = 20'(1) << 18,
        S_DONE     = 20'(1) << 19
    } t_state;

    t_state r_state, n_state;

    logic [VW-1:0]  r_clr, n_clr;
    logic [10:0]    r_var_count, n_var_count;
    logic [16:0]    r_thr, n_thr;
    logic [LW-1:0]  r_ltot, n_ltot;
    logic [CW-1:0]  r_ctot, n_ctot;
    logic [30:0]    r_rcl, n_rcl;
    logic [15:0]    r_coin, n_coin;
    logic [30:0]    r_rlit, n_rlit;
    logic [CW-1:0]  r_c, n_c;
    logic [LW-1:0]  r_i, n_i;
    logic [LW-1:0]  r_end, n_end;
    logic           r_csat, n_csat;
    logic [CW-1:0]  r_ucnt, n_ucnt;
    logic [CW-1:0]  r_sat, n_sat;
    logic           r_greedy, n_greedy;
    logic [VW-1:0]  r_trial, n_trial;
    logic [VW-1:0]  r_v, n_v;
    logic           r_pos, n_pos;
    logic [CAW-1:0] r_pick, n_pick;
    logic [LW-1:0]  r_pend, n_pend;
    logic [LW-1:0]  r_start, n_start;
    logic [LW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_best, n_best;
    logic           r_have, n_have;
    logic [VW-1:0]  r_flip, n_flip;
    logic           r_rd_ok, n_rd_ok;
    logic           r_res_all, n_res_all;
    logic           r_res_read, n_res_read;
    logic           r_out_valid, n_out_valid;
    logic           r_o_all, n_o_all;
    logic [10:0]    r_o_flip, n_o_flip;
    logic [12:0]    r_o_unsat, n_o_unsat;
    logic           r_o_read, n_o_read;
    logic           r_o_ovf, n_o_ovf;

    // formula and assignment memories
    logic [11:0]    r_lit_mem [MAX_LITERALS];
    logic [LW-1:0]  r_off_mem [MAX_CLAUSES];
    logic [CAW-1:0] r_uns_mem [MAX_CLAUSES];
    logic           r_asg_mem [MAX_VARS + 1];
    logic [11:0]    r_lit_rd;
    logic [LW-1:0]  r_off_rd;
    logic [CAW-1:0] r_uns_rd;
    logic           r_asg_rd;

    logic           lit_we;
    logic [LAW-1:0] lit_waddr, lit_raddr;
    logic           off_we;
    logic [CAW-1:0] off_waddr, off_raddr;
    logic [LW-1:0]  off_wdata;
    logic           uns_we;
    logic [CAW-1:0] uns_waddr, uns_raddr;
    logic [CAW-1:0] uns_wdata;
    logic           asg_we;
    logic [VW-1:0]  asg_waddr, asg_raddr;
    logic           asg_wdata;

    logic           div_start;
    logic [30:0]    div_dividend;
    logic [DW-1:0]  div_divisor;
    logic           w_div_done;
    logic [DW-1:0]  w_div_rem;

    logic           w_in_acc;
    logic           w_neg;
    logic [12:0]    w_abs;
    logic           w_dead;
    logic [VW-1:0]  w_var;
    logic           w_bit;
    logic           w_set_ok;
    logic           w_ovf;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // decode the literal that the last literal-memory read returned
    always_comb begin
        w_neg  = r_lit_rd[11];
        w_abs  = w_neg ? (13'd0 - {r_lit_rd[11], r_lit_rd}) : {1'b0, r_lit_rd};
        w_dead = (w_abs == 13'd0) || (32'(w_abs) > 32'(r_var_count))
                 || (32'(w_abs) > MAX_VARS);
        w_var  = VW'(w_abs);
        w_bit  = r_asg_rd ^ (r_v == r_trial);
        w_set_ok = (i_var_index != 11'd0) && (32'(i_var_index) <= MAX_VARS);
        w_ovf  = (32'(r_ltot) >= MAX_LITERALS) || (32'(r_ctot) >= MAX_CLAUSES);
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_var_count = r_var_count;
        n_thr       = r_thr;
        n_ltot      = r_ltot;
        n_ctot      = r_ctot;
        n_rcl       = r_rcl;
        n_coin      = r_coin;
        n_rlit      = r_rlit;
        n_c         = r_c;
        n_i         = r_i;
        n_end       = r_end;
        n_csat      = r_csat;
        n_ucnt      = r_ucnt;
        n_sat       = r_sat;
        n_greedy    = r_greedy;
        n_trial     = r_trial;
        n_v         = r_v;
        n_pos       = r_pos;
        n_pick      = r_pick;
        n_pend      = r_pend;
        n_start     = r_start;
        n_j         = r_j;
        n_best      = r_best;
        n_have      = r_have;
        n_flip      = r_flip;
        n_rd_ok     = r_rd_ok;
        n_res_all   = r_res_all;
        n_res_read  = r_res_read;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_all     = r_o_all;
        n_o_flip    = r_o_flip;
        n_o_unsat   = r_o_unsat;
        n_o_read    = r_o_read;
        n_o_ovf     = r_o_ovf;

        lit_we       = 1'b0;
        lit_waddr    = LAW'(r_ltot);
        lit_raddr    = LAW'(r_i);
        off_we       = 1'b0;
        off_waddr    = CAW'(r_ctot);
        off_wdata    = r_ltot + 1'b1;
        off_raddr    = CAW'(r_c);
        uns_we       = 1'b0;
        uns_waddr    = CAW'(r_ucnt);
        uns_wdata    = CAW'(r_c);
        uns_raddr    = CAW'(w_div_rem);
        asg_we       = 1'b0;
        asg_waddr    = r_clr;
        asg_wdata    = 1'b0;
        asg_raddr    = w_var;
        div_start    = 1'b0;
        div_dividend = r_rcl;
        div_divisor  = DW'(r_ucnt);

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VAR_COUNT: n_var_count = i_cfg_data[10:0];
                CFG_GREEDY:    n_thr = i_cfg_data;
                default:       n_thr = r_thr;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                asg_we = 1'b1;
                if (r_clr == VW'(MAX_VARS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                asg_raddr = VW'(i_var_index);
                if (w_in_acc) begin
                    n_rcl  = i_rand_clause;
                    n_coin = i_rand_coin;
                    n_rlit = i_rand_literal;
                    unique case (i_opcode)
                        OP_LOAD: begin
                            n_out_valid = 1'b1;
                            n_o_all     = 1'b0;
                            n_o_flip    = '0;
                            n_o_unsat   = '0;
                            n_o_read    = 1'b0;
                            n_o_ovf     = w_ovf;
                            if (!w_ovf) begin
                                lit_we = 1'b1;
                                n_ltot = r_ltot + 1'b1;
                                if (i_clause_end) begin
                                    off_we = 1'b1;
                                    n_ctot = r_ctot + 1'b1;
                                end
                            end
                        end
                        OP_SET: begin
                            n_out_valid = 1'b1;
                            n_o_all     = 1'b0;
                            n_o_flip    = '0;
                            n_o_unsat   = '0;
                            n_o_read    = 1'b0;
                            n_o_ovf     = 1'b0;
                            if (w_set_ok) begin
                                asg_we    = 1'b1;
                                asg_waddr = VW'(i_var_index);
                                asg_wdata = i_var_value;
                            end
                        end
                        OP_READ: begin
                            n_rd_ok   = w_set_ok;
                            n_flip    = '0;
                            n_ucnt    = '0;
                            n_res_all = 1'b0;
                            n_state   = S_RD;
                        end
                        OP_FLIP: begin
                            n_res_read = 1'b0;
                            n_res_all  = 1'b0;
                            n_flip     = '0;
                            n_c        = '0;
                            n_i        = '0;
                            n_ucnt     = '0;
                            n_sat      = '0;
                            n_greedy   = 1'b0;
                            n_trial    = '0;
                            n_state    = S_SC_START;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                n_res_read = r_rd_ok & r_asg_rd;
                n_state    = S_DONE;
            end
            S_SC_START: begin
                if (r_c == r_ctot) begin
                    if (r_greedy) begin
                        // keep the first trial with the highest satisfied count
                        if (!r_have || (r_sat > r_best)) begin
                            n_best = r_sat;
                            n_flip = r_trial;
                            n_have = 1'b1;
                        end
                        n_j     = r_j + 1'b1;
                        n_state = S_GR_LIT;
                    end else if (r_ucnt == '0) begin
                        n_res_all = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV1;
                    end
                end else begin
                    n_state = S_SC_OFF;
                end
            end
            S_SC_OFF: begin
                n_end   = r_off_rd;
                n_csat  = 1'b0;
                n_state = S_SC_LIT;
            end
            S_SC_LIT: begin
                if (r_i == r_end) begin
                    if (r_csat) begin
                        n_sat = r_sat + 1'b1;
                    end else if (!r_greedy) begin
                        uns_we = 1'b1;
                        n_ucnt = r_ucnt + 1'b1;
                    end
                    n_c     = r_c + 1'b1;
                    n_state = S_SC_START;
                end else if (r_csat) begin
                    // clause already true: skip its remaining literals
                    n_i = r_end;
                end else begin
                    n_state = S_SC_LW;
                end
            end
            S_SC_LW: begin
                if (w_dead) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SC_LIT;
                end else begin
                    n_v     = w_var;
                    n_pos   = !w_neg;
                    n_state = S_SC_EV;
                end
            end
            S_SC_EV: begin
                if (r_pos ? w_bit : !w_bit) begin
                    n_csat = 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_SC_LIT;
            end
            S_DIV1: begin
                if (w_div_done) begin
                    n_state = S_PK1;
                end
            end
            S_PK1: begin
                n_pick    = r_uns_rd;
                off_raddr = r_uns_rd;
                n_state   = S_PK2;
            end
            S_PK2: begin
                n_pend = r_off_rd;
                if (r_pick == '0) begin
                    n_start = '0;
                    n_state = S_PK4;
                end else begin
                    off_raddr = r_pick - 1'b1;
                    n_state   = S_PK3;
                end
            end
            S_PK3: begin
                n_start = r_off_rd;
                n_state = S_PK4;
            end
            S_PK4: begin
                if ({1'b0, r_coin} < r_thr) begin
                    div_start    = 1'b1;
                    div_dividend = r_rlit;
                    div_divisor  = DW'(r_pend - r_start);
                    n_state      = S_DIV2;
                end else begin
                    n_j      = r_start;
                    n_have   = 1'b0;
                    n_greedy = 1'b1;
                    n_state  = S_GR_LIT;
                end
            end
            S_DIV2: begin
                lit_raddr = LAW'(r_start + LW'(w_div_rem));
                if (w_div_done) begin
                    n_state = S_RND_LW;
                end
            end
            S_RND_LW: begin
                n_flip  = w_dead ? '0 : w_var;
                n_state = S_FLIP;
            end
            S_GR_LIT: begin
                lit_raddr = LAW'(r_j);
                if (r_j == r_pend) begin
                    n_state = S_FLIP;
                end else begin
                    n_state = S_GR_LW;
                end
            end
            S_GR_LW: begin
                if (w_dead) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_GR_LIT;
                end else begin
                    n_trial = w_var;
                    n_c     = '0;
                    n_i     = '0;
                    n_sat   = '0;
                    n_state = S_SC_START;
                end
            end
            S_FLIP: begin
                asg_raddr = r_flip;
                if (r_flip == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FLIP2;
                end
            end
            S_FLIP2: begin
                asg_we    = 1'b1;
                asg_waddr = r_flip;
                asg_wdata = !r_asg_rd;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_all     = r_res_all;
                    n_o_flip    = 11'(r_flip);
                    n_o_unsat   = 13'(r_ucnt);
                    n_o_read    = r_res_read;
                    n_o_ovf     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_var_count <= VAR_COUNT_RST;
            r_thr       <= GREEDY_RST;
            r_ltot      <= '0;
            r_ctot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_var_count <= n_var_count;
            r_thr       <= n_thr;
            r_ltot      <= n_ltot;
            r_ctot      <= n_ctot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rcl      <= n_rcl;
        r_coin     <= n_coin;
        r_rlit     <= n_rlit;
        r_c        <= n_c;
        r_i        <= n_i;
        r_end      <= n_end;
        r_csat     <= n_csat;
        r_ucnt     <= n_ucnt;
        r_sat      <= n_sat;
        r_greedy   <= n_greedy;
        r_trial    <= n_trial;
        r_v        <= n_v;
        r_pos      <= n_pos;
        r_pick     <= n_pick;
        r_pend     <= n_pend;
        r_start    <= n_start;
        r_j        <= n_j;
        r_best     <= n_best;
        r_have     <= n_have;
        r_flip     <= n_flip;
        r_rd_ok    <= n_rd_ok;
        r_res_all  <= n_res_all;
        r_res_read <= n_res_read;
        r_o_all    <= n_o_all;
        r_o_flip   <= n_o_flip;
        r_o_unsat  <= n_o_unsat;
        r_o_read   <= n_o_read;
        r_o_ovf    <= n_o_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (lit_we) begin
            r_lit_mem[lit_waddr] <= i_literal;
        end
        r_lit_rd <= r_lit_mem[lit_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_off_mem[off_waddr] <= off_wdata;
        end
        r_off_rd <= r_off_mem[off_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (uns_we) begin
            r_uns_mem[uns_waddr] <= uns_wdata;
        end
        r_uns_rd <= r_uns_mem[uns_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (asg_we) begin
            r_asg_mem[asg_waddr] <= asg_wdata;
        end
        r_asg_rd <= r_asg_mem[asg_raddr];
    end

    wsf_rem #(
        .DW (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign o_out_valid     = r_out_valid;
    assign o_all_satisfied = r_o_all;
    assign o_flipped_var   = r_o_flip;
    assign o_unsat_count   = r_o_unsat;
    assign o_read_value    = r_o_read;
    assign o_load_overflow = r_o_ovf;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the WalkSAT flip engine: driven items, predicted results.
`timescale 1ns / 1ps

module testbench;
    import wsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LIT_DEPTH      = DEF_MAX_LITERALS;
    localparam int CLAUSE_DEPTH   = DEF_MAX_CLAUSES;
    localparam int VAR_DEPTH      = DEF_MAX_VARS;

    typedef struct {
        t_opcode            op;
        logic signed [11:0] lit;
        logic               cend;
        logic [10:0]        vidx;
        logic               vval;
        logic [30:0]        rcl;
        logic [15:0]        coin;
        logic [30:0]        rlit;
        bit                 drain_first;
    } item_t;

    typedef struct {
        logic        all_sat;
        logic [10:0] flip;
        logic [12:0] unsat;
        logic        rd;
        logic        ovf;
    } result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = '0;
    logic signed [11:0] i_literal = '0;
    logic               i_clause_end = 1'b0;
    logic [10:0]        i_var_index = '0;
    logic               i_var_value = 1'b0;
    logic [30:0]        i_rand_clause = '0;
    logic [15:0]        i_rand_coin = '0;
    logic [30:0]        i_rand_literal = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_all_satisfied;
    logic [10:0]        o_flipped_var;
    logic [12:0]        o_unsat_count;
    logic               o_read_value;
    logic               o_load_overflow;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [16:0]        i_cfg_data = '0;

    walksat_flip_engine dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    int  lit_mem [LIT_DEPTH];
    int  clause_end_at [CLAUSE_DEPTH];
    int  unsat_ids [CLAUSE_DEPTH];
    bit  assign_bits [0:VAR_DEPTH];
    int  clause_cnt = 0;
    int  lit_cnt = 0;
    int  var_cnt = 1024;
    int  greedy_thr = 32768;

    item_t   pending_q[$];
    result_t expected_q[$];

    int mismatches = 0;
    int n_flips = 0, n_all_sat = 0, n_greedy = 0, n_random = 0, n_overflow = 0, n_checked = 0;

    // generator bookkeeping
    int gen_lits = 0, gen_clauses = 0, gen_vmax = 8;

    function automatic int live_var(int l);
        int v;
        int live;
        v = l < 0 ? -l : l;
        live = var_cnt < VAR_DEPTH ? var_cnt : VAR_DEPTH;
        return (v == 0 || v > live) ? 0 : v;
    endfunction

    function automatic bit literal_true(int l);
        int v;
        v = live_var(l);
        if (v == 0) return 1'b0;
        return l > 0 ? assign_bits[v] : !assign_bits[v];
    endfunction

    function automatic int clause_first(int c);
        return c == 0 ? 0 : clause_end_at[c - 1];
    endfunction

    function automatic bit clause_satisfied(int c);
        for (int i = clause_first(c); i < clause_end_at[c]; i++)
            if (literal_true(lit_mem[i])) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int satisfied_clauses();
        int n;
        n = 0;
        for (int c = 0; c < clause_cnt; c++)
            if (clause_satisfied(c)) n++;
        return n;
    endfunction

    task automatic predict_item(input item_t it);
        result_t r;
        int n, pick, s, size, flip, best, fit, v;
        r = '{default: '0};
        case (it.op)
            OP_LOAD: begin
                if (lit_cnt >= LIT_DEPTH || clause_cnt >= CLAUSE_DEPTH) begin
                    r.ovf = 1'b1;
                    n_overflow++;
                end else begin
                    lit_mem[lit_cnt] = int'(it.lit);
                    lit_cnt++;
                    if (it.cend) begin
                        clause_end_at[clause_cnt] = lit_cnt;
                        clause_cnt++;
                    end
                end
            end
            OP_SET: if (it.vidx >= 1 && it.vidx <= VAR_DEPTH) assign_bits[it.vidx] = it.vval;
            OP_READ: if (it.vidx >= 1 && it.vidx <= VAR_DEPTH) r.rd = assign_bits[it.vidx];
            default: begin
                n_flips++;
                n = 0;
                for (int c = 0; c < clause_cnt; c++)
                    if (!clause_satisfied(c)) begin
                        unsat_ids[n] = c;
                        n++;
                    end
                r.unsat = n[12:0];
                if (n == 0) begin
                    r.all_sat = 1'b1;
                    n_all_sat++;
                end else begin
                    pick = unsat_ids[int'(it.rcl) % n];
                    s = clause_first(pick);
                    size = clause_end_at[pick] - s;
                    flip = 0;
                    if (int'(it.coin) < greedy_thr) begin
                        n_random++;
                        flip = live_var(lit_mem[s + int'(it.rlit) % size]);
                    end else begin
                        n_greedy++;
                        best = -1;
                        for (int j = 0; j < size; j++) begin
                            v = live_var(lit_mem[s + j]);
                            if (v != 0) begin
                                assign_bits[v] = !assign_bits[v];
                                fit = satisfied_clauses();
                                assign_bits[v] = !assign_bits[v];
                                if (fit > best) begin
                                    best = fit;
                                    flip = v;
                                end
                            end
                        end
                    end
                    if (flip != 0) assign_bits[flip] = !assign_bits[flip];
                    r.flip = flip[10:0];
                end
            end
        endcase
        expected_q.push_back(r);
    endtask

    // sender: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        item_t it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                it.op = t_opcode'(i_opcode);
                it.lit = i_literal;
                it.cend = i_clause_end;
                it.vidx = i_var_index;
                it.vval = i_var_value;
                it.rcl = i_rand_clause;
                it.coin = i_rand_coin;
                it.rlit = i_rand_literal;
                predict_item(it);
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain_first &&
                           (expected_q.size() != 0 || i_in_valid))) begin
                it = pending_q.pop_front();
                i_opcode <= it.op;
                i_literal <= it.lit;
                i_clause_end <= it.cend;
                i_var_index <= it.vidx;
                i_var_value <= it.vval;
                i_rand_clause <= it.rcl;
                i_rand_coin <= it.coin;
                i_rand_literal <= it.rlit;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each result; the stall pattern switches between random modes
    int stall_mode = 0, stall_tick = 0;
    always @(posedge i_clk) begin
        result_t e;
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.all_sat !== o_all_satisfied || e.flip !== o_flipped_var ||
                    e.unsat !== o_unsat_count || e.rd !== o_read_value ||
                    e.ovf !== o_load_overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp sat=%0d flip=%0d unsat=%0d ",
                                  "rd=%0d ovf=%0d, got sat=%0d flip=%0d unsat=%0d ",
                                  "rd=%0d ovf=%0d"},
                                 $realtime, e.all_sat, e.flip, e.unsat, e.rd, e.ovf,
                                 o_all_satisfied, o_flipped_var, o_unsat_count,
                                 o_read_value, o_load_overflow);
                end
            end
        end
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog on cycles with no handshake
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic item_t random_item(t_opcode op);
        item_t it;
        it.op = op;
        it.lit = 12'($urandom_range(0, 2048)) - 12'sd1024;
        it.cend = $urandom_range(0, 1);
        it.vidx = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1024))
                                               : 11'($urandom_range(0, gen_vmax));
        it.vval = $urandom_range(0, 1);
        it.rcl = 31'($urandom);
        it.coin = 16'($urandom_range(0, 65535));
        it.rlit = 31'($urandom);
        it.drain_first = 1'b0;
        return it;
    endfunction

    task automatic queue_item(item_t it);
        if (it.op == OP_LOAD) begin
            gen_lits++;
            if (it.cend) gen_clauses++;
        end
        pending_q.push_back(it);
    endtask

    task automatic queue_load(int l, bit cend);
        item_t it;
        it = random_item(OP_LOAD);
        it.lit = 12'(l);
        it.cend = cend;
        queue_item(it);
    endtask

    task automatic queue_flip(int coin, int rcl, int rlit);
        item_t it;
        it = random_item(OP_FLIP);
        it.coin = 16'(coin);
        it.rcl = 31'(rcl);
        it.rlit = 31'(rlit);
        queue_item(it);
    endtask

    task automatic queue_var_op(t_opcode op, int idx, bit val);
        item_t it;
        it = random_item(op);
        it.vidx = 11'(idx);
        it.vval = val;
        queue_item(it);
    endtask

    task automatic queue_random(int count);
        item_t it;
        int sel, len, mag;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20 && gen_clauses < 24) begin
                // well-formed clause of 1..4 literals, mostly on variables 1..gen_vmax
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++) begin
                    mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024)
                                                      : $urandom_range(1, gen_vmax);
                    queue_load($urandom_range(0, 1) ? mag : -mag, j == len - 1);
                end
            end else if (sel < 25) begin
                it = random_item(OP_LOAD);
                it.cend = 1'b0;
                queue_item(it);
            end else if (sel < 45) begin
                queue_item(random_item(OP_SET));
            end else if (sel < 55) begin
                queue_item(random_item(OP_READ));
            end else begin
                it = random_item(OP_FLIP);
                it.drain_first = ($urandom_range(0, 15) == 0);
                queue_item(it);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, int data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 17'(data);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VAR_COUNT) var_cnt = data & 'h7FF;
        else greedy_thr = data & 'h1FFFF;
    endtask

    task automatic run_phase(int vc, int thr, int vmax, int count);
        wait_idle();
        write_reg(CFG_VAR_COUNT, vc);
        write_reg(CFG_GREEDY, thr);
        gen_vmax = vmax;
        queue_random(count);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty formula, range edges of set and read, dead literals, both moves
        queue_flip(0, 0, 0);
        queue_var_op(OP_READ, 0, 1'b0);
        queue_var_op(OP_SET, 1024, 1'b1);
        queue_var_op(OP_READ, 1024, 1'b0);
        queue_var_op(OP_SET, 0, 1'b1);
        queue_var_op(OP_READ, 0, 1'b0);
        queue_load(1, 1'b0);
        queue_load(-2, 1'b0);
        queue_load(1024, 1'b1);
        queue_load(0, 1'b0);
        queue_load(3, 1'b1);
        queue_load(-1024, 1'b0);
        queue_load(5, 1'b1);
        queue_load(7, 1'b0);
        queue_flip(0, 0, 0);
        queue_flip(65535, 'h7FFFFFFF, 'h7FFFFFFF);
        queue_flip(32767, 1, 1);
        queue_flip(32768, 2, 3);
        queue_var_op(OP_SET, 3, 1'b1);
        queue_var_op(OP_READ, 3, 1'b0);
        queue_flip(0, 'h7FFFFFFF, 0);
        gen_vmax = 8;

        run_phase(8, 32768, 8, 24);
        run_phase(1, 0, 4, 12);
        run_phase(2047, 65536, 10, 20);
        run_phase(12, $urandom_range(0, 65536), 12, 24);

        wait_idle();
        queue_var_op(OP_READ, 1024, 1'b0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        mismatches += expected_q.size();
        $display("checked %0d results: %0d flip steps (%0d all satisfied, %0d random, %0d greedy)",
                 n_checked, n_flips, n_all_sat, n_random, n_greedy);
        $display("formula holds %0d literals in %0d clauses, %0d loads dropped, %0d mismatches",
                 lit_cnt, clause_cnt, n_overflow, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
